@@ sv/fcw_pkg.sv @@
package fcw_pkg;

	// fat store geometry
	localparam int FAT_BYTES = 8192;
	localparam int FAT_AW    = $clog2(FAT_BYTES);
	localparam logic [13:0] FAT_LIMIT = 14'(FAT_BYTES);

	// fat12 constants
	localparam logic [11:0] END_MARK  = 12'hFF8;
	localparam logic [11:0] MIN_CLUST = 12'd2;

	// item modes
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_START   = 2'd1;
	localparam logic [1:0] MODE_ADVANCE = 2'd2;

	// configuration register indexes
	localparam logic REG_DATA_START = 1'b0;
	localparam logic REG_SPC        = 1'b1;

	// result kinds issued by the controller
	localparam logic [2:0] EMIT_NONE  = 3'd0;
	localparam logic [2:0] EMIT_ZERO  = 3'd1;
	localparam logic [2:0] EMIT_NOACT = 3'd2;
	localparam logic [2:0] EMIT_LOW   = 3'd3;
	localparam logic [2:0] EMIT_VISIT = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [12:0] fat_addr;
		logic [7:0]  fat_byte;
		logic [11:0] first_cluster;
	} item_t;

	typedef struct packed {
		logic [11:0] cluster;
		logic [19:0] sector_addr;
		logic [11:0] next_cluster;
		logic        last;
		logic        error;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic       wr;       // write fat byte of the accepted item
		logic       take;     // latch the selected cluster
		logic       set_cur;  // current cluster takes first_cluster
		logic       rd_hi;    // capture low byte, read high byte
		logic [2:0] emit;     // result kind to register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sel_lt2;       // selected cluster below two
		logic chain_active;
	} status_t;

endpackage

@@ sv/fcw_ram.sv @@
module fcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/fcw_ctrl.sv @@
module fcw_ctrl import fcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  status_t    status,
	output logic       busy,
	output cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RD_LO = 2'd1;
	localparam logic [1:0] ST_RD_HI = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.emit = EMIT_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (mode)
						MODE_LOAD: begin
							cmd.wr   = 1'b1;
							cmd.emit = EMIT_ZERO;
						end
						MODE_START: begin
							cmd.take    = 1'b1;
							cmd.set_cur = 1'b1;
							if (status.sel_lt2) begin
								cmd.emit = EMIT_LOW;
							end else begin
								state_d = ST_RD_LO;
							end
						end
						MODE_ADVANCE: begin
							if (!status.chain_active) begin
								cmd.emit = EMIT_NOACT;
							end else begin
								cmd.take = 1'b1;
								if (status.sel_lt2) begin
									cmd.emit = EMIT_LOW;
								end else begin
									state_d = ST_RD_LO;
								end
							end
						end
						default: begin
							cmd.emit = EMIT_ZERO;
						end
					endcase
				end
			end
			ST_RD_LO: begin
				cmd.rd_hi = 1'b1;
				state_d   = ST_RD_HI;
			end
			ST_RD_HI: begin
				cmd.emit = EMIT_VISIT;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/fcw_dp.sv @@
module fcw_dp import fcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  cmd_t        cmd,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data,
	output status_t     status,
	output logic        done,
	output result_t     result
);

	logic [15:0]       data_start_q;
	logic [7:0]        spc_q;
	logic [11:0]       cur_q;
	logic              active_q;
	logic [11:0]       c_q;
	logic [7:0]        lo_q;
	logic              rd_ok_q;
	logic              valid_q;
	result_t           res_q;

	logic [11:0]       sel_c;
	logic [11:0]       idx_c;
	logic [12:0]       idx_base;
	logic [12:0]       rd_idx;
	logic              rd_ok;
	logic              wr_ok;
	logic [FAT_AW-1:0] ram_addr;
	logic [7:0]        ram_rdata;
	logic [7:0]        hi_byte;
	logic [15:0]       word;
	logic [11:0]       next_c;
	logic [19:0]       product;
	logic [19:0]       sector;
	logic [11:0]       c_m2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= 16'd33;
			spc_q        <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DATA_START: data_start_q <= cfg_data;
				REG_SPC:        spc_q        <= cfg_data[7:0];
				default:        ;
			endcase
		end
	end

	// cluster for the accepted item
	assign sel_c = (item.mode == MODE_START) ? item.first_cluster : cur_q;
	assign status.sel_lt2      = (sel_c < MIN_CLUST);
	assign status.chain_active = active_q;

	// fat byte index: cluster * 3 / 2, plus one for the high byte
	assign idx_c    = cmd.rd_hi ? c_q : sel_c;
	assign idx_base = {1'b0, idx_c} + {2'b0, idx_c[11:1]};
	assign rd_idx   = idx_base + {12'd0, cmd.rd_hi};
	assign rd_ok    = ({1'b0, rd_idx} < FAT_LIMIT);
	assign wr_ok    = ({1'b0, item.fat_addr} < FAT_LIMIT);
	assign ram_addr = cmd.wr ? item.fat_addr[FAT_AW-1:0] : rd_idx[FAT_AW-1:0];

	fcw_ram #(
		.WIDTH(8),
		.DEPTH(FAT_BYTES)
	) u_fat (
		.clk  (clk),
		.we   (cmd.wr && wr_ok),
		.addr (ram_addr),
		.wdata(item.fat_byte),
		.rdata(ram_rdata)
	);

	// entry unpack and sector address
	assign hi_byte = rd_ok_q ? ram_rdata : 8'd0;
	assign word    = {hi_byte, lo_q};
	assign next_c  = c_q[0] ? word[15:4] : word[11:0];
	assign c_m2    = c_q - MIN_CLUST;
	assign product = {8'd0, c_m2} * {12'd0, spc_q};
	assign sector  = {4'd0, data_start_q} + product;

	// latched cluster, low byte and read range flag
	always_ff @(posedge clk) begin
		rd_ok_q <= rd_ok;
		if (cmd.take) begin
			c_q <= sel_c;
		end
		if (cmd.rd_hi) begin
			lo_q <= rd_ok_q ? ram_rdata : 8'd0;
		end
	end

	// chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (cmd.set_cur) begin
				cur_q <= item.first_cluster;
			end
			if (cmd.emit == EMIT_LOW) begin
				active_q <= 1'b0;
			end else if (cmd.emit == EMIT_VISIT) begin
				active_q <= (next_c < END_MARK);
				if (next_c < END_MARK) begin
					cur_q <= next_c;
				end
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (cmd.emit != EMIT_NONE);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			EMIT_ZERO: begin
				res_q <= '0;
			end
			EMIT_NOACT: begin
				res_q <= '{12'd0, 20'd0, 12'd0, 1'b0, 1'b1};
			end
			EMIT_LOW: begin
				res_q <= '{sel_c, 20'd0, 12'd0, 1'b0, 1'b1};
			end
			EMIT_VISIT: begin
				res_q.cluster      <= c_q;
				res_q.sector_addr  <= sector;
				res_q.next_cluster <= next_c;
				res_q.last         <= (next_c >= END_MARK);
				res_q.error        <= 1'b0;
			end
			default: ;
		endcase
	end

	assign done   = valid_q;
	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_emit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EMIT_NONE) |=> valid_q)
		else $error("issued result did not strobe");
	a_last_ends_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.last) |-> !active_q)
		else $error("chain still active after end mark");
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.error) |->
		(res_q.sector_addr == 20'd0 && res_q.next_cluster == 12'd0 && !res_q.last))
		else $error("error result carries chain data");
	a_no_write_while_reading: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_hi |-> !cmd.wr)
		else $error("fat write during chain read");
`endif

endmodule

@@ sv/fat12_cluster_chain_walker_unit.sv @@
// channel  | handshake       | payload                         | direction
// ---------+-----------------+---------------------------------+----------
// item     | start / busy    | item (mode, fat_addr, ...)      | in
// result   | done            | result (cluster, sector_addr..) | out
// config   | cfg_we          | cfg_idx, cfg_data               | in
//
// a fat load, an unused mode, an advance with no chain or a cluster below two
// needs no fat read: busy stays low and done pulses on the next cycle.
// a chain visit makes two reads of the single-port fat byte store and then
// registers the result; done pulses once the second byte has returned.
// reset clears the controller and the chain state and sets config defaults;
// the fat store is not cleared and must be loaded before a chain is walked.
// done lasts one cycle and the receiver cannot stall it.
module fat12_cluster_chain_walker_unit import fcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	fcw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (item.mode),
		.status(status),
		.busy  (busy),
		.cmd   (cmd)
	);

	// fat store, chain state and result register
	fcw_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.status  (status),
		.done    (done),
		.result  (result)
	);

endmodule
